>>> hdl/sgb_pkg.sv
`default_nettype none

package sgb_pkg;

    // Image limits
    localparam int MAX_WIDTH     = 128;
    localparam int MAX_HEIGHT    = 128;
    localparam int MAX_CHANNELS  = 4;
    localparam int MAX_HALF_TAPS = 8;

    // Storage sizes
    localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int ROW_DEPTH   = MAX_WIDTH * MAX_CHANNELS;
    localparam int ROW_AW      = $clog2(ROW_DEPTH);

    // Divider operand widths
    localparam int DIV_NW = 16;
    localparam int DIV_DW = 10;

    // Configuration register indexes
    localparam logic [3:0] REG_IMAGE_WIDTH   = 4'd0;
    localparam logic [3:0] REG_IMAGE_HEIGHT  = 4'd1;
    localparam logic [3:0] REG_CHANNEL_COUNT = 4'd2;
    localparam logic [3:0] REG_HALF_TAPS     = 4'd3;
    localparam logic [3:0] REG_TAP_WEIGHTS   = 4'd4;
    localparam logic [3:0] REG_BORDER_MODE   = 4'd5;
    localparam logic [3:0] REG_FIRST_ROW     = 4'd6;
    localparam logic [3:0] REG_END_ROW       = 4'd7;

    // Command codes
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // Border modes
    localparam logic [1:0] BORDER_REPLICATE = 2'd0;
    localparam logic [1:0] BORDER_REFLECT   = 2'd1;
    localparam logic [1:0] BORDER_WRAP      = 2'd2;
    localparam logic [1:0] BORDER_REVERSE   = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] pixel_value;
    } sgb_in_t;

    typedef struct packed {
        logic [7:0] out_value;
        logic       last_value;
    } sgb_out_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_L_PREP,
        S_L_WRITE,
        S_R_PREP,
        S_R_WRAP,
        S_D1_GO,
        S_D1_WAIT,
        S_D2_GO,
        S_D2_WAIT,
        S_C_ADDR,
        S_C_READ,
        S_T_IDX,
        S_T_FOLD,
        S_T_ADDN,
        S_T_ADDP,
        S_T_RDP,
        S_T_SUM,
        S_T_MAC,
        S_V_WRITE,
        S_FIN
    } sgb_state_t;

    // Take one reflection step of an index toward 0..size-1; an index in range is kept
    function automatic logic signed [9:0] fold_step(input logic signed [9:0] idx,
                                                    input logic [7:0] size,
                                                    input logic [1:0] mode);
        logic signed [9:0] p;
        logic signed [9:0] sz;
        p  = idx;
        sz = signed'({2'b00, size});
        if (size <= 8'd1)
        begin
            return 10'sd0;
        end
        case (mode)
            BORDER_REFLECT:
            begin
                if (p < 10'sd0) p = -p;
                if (p >= sz) p = (sz - 10'sd1) + (sz - 10'sd1) - p;
            end
            BORDER_WRAP:
            begin
                if (p < 10'sd0) p = p + sz;
                else if (p >= sz) p = p - sz;
            end
            BORDER_REVERSE:
            begin
                if (p < 10'sd0) p = -p - 10'sd1;
                if (p >= sz) p = sz + sz - 10'sd1 - p;
            end
            default:
            begin
                if (p < 10'sd0) p = 10'sd0;
                else if (p >= sz) p = sz - 10'sd1;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sgb_ram.sv
`default_nettype none

module sgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read on one port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

>>> hdl/sgb_div.sv
`default_nettype none

module sgb_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [sgb_pkg::DIV_NW-1:0]  dividend,
    input  wire logic [sgb_pkg::DIV_DW-1:0]  divisor,
    output logic      [sgb_pkg::DIV_NW-1:0]  quotient,
    output logic      [sgb_pkg::DIV_DW-1:0]  remainder,
    output logic                             done
);
    import sgb_pkg::*;

    localparam int CW = $clog2(DIV_NW);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DIV_NW-1:0] quo_reg, quo_next;
    logic [DIV_DW:0]   rem_reg, rem_next;
    logic [DIV_DW-1:0] dvs_reg, dvs_next;
    logic [DIV_DW:0]   trial;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg[DIV_DW-1:0], quo_reg[DIV_NW-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[DIV_NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[DIV_NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(DIV_NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg[DIV_DW-1:0];
    assign done      = done_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg)) else $error("divider done without run");
    a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(start)) |-> !busy_reg) else $error("divider still busy at done");
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rem_reg < {1'b0, dvs_reg})) else $error("remainder not reduced");
`endif

endmodule

`default_nettype wire

>>> hdl/separable_gaussian_blur_u8.sv
`default_nettype none

// Separable Gaussian blur on an 8-bit interleaved image held in an internal frame store.
// Command channel: present cmd with start high while busy is low; the command is taken
// at that clock edge and busy rises until it is done. A load (func 0) writes the next
// source byte in raster order and gives no result. A request (func 1)
// gives the next filtered byte of the stripe first_row..end_row-1 on result, marked by
// done for exactly one cycle; the receiver cannot stall and must take it then.
// Request sequence: setup (stripe size, position wrap and two 16-step divisions for
// row and pixel position), then the kernel steps with any border reflections
// (2*half_taps-1 taps paired into half_taps steps), then one finish step; done follows
// in the next cycle. The first byte of each stripe row also runs the vertical pass
// first: half_taps kernel steps and one row-buffer write for each of row_length
// elements, plus their border reflections. With half_taps 0 a request is a plain copy.
// The single shared multiplier and the single port of each memory serialize this work.
// An empty stripe returns to idle with no result.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready stays high.
// Write registers only while the block is idle. Reset clears registers to their defaults
// and both positions to zero; memory contents are undefined until loaded.

module separable_gaussian_blur_u8 (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire sgb_pkg::sgb_in_t  cmd,
    output logic                   done,
    output sgb_pkg::sgb_out_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [3:0]        cfg_index,
    input  wire logic [63:0]       cfg_data
);
    import sgb_pkg::*;

    // Configuration registers
    logic [7:0]  image_width_reg;
    logic [7:0]  image_height_reg;
    logic [2:0]  channel_count_reg;
    logic [3:0]  half_taps_reg;
    logic [63:0] tap_weights_reg;
    logic [1:0]  border_mode_reg;
    logic [6:0]  first_row_reg;
    logic [7:0]  end_row_reg;

    // Control state
    sgb_state_t    state_reg, state_next;
    logic [15:0]   lp_reg, lp_next;
    logic [15:0]   pos_reg, pos_next;
    logic          done_reg, done_next;

    // Payload
    sgb_in_t       in_reg, in_next;
    sgb_out_t      result_reg, result_next;
    logic [16:0]   ft_reg, ft_next;
    logic [16:0]   total_reg, total_next;
    logic [6:0]    y_reg, y_next;
    logic [8:0]    col_reg, col_next;
    logic [6:0]    px_reg, px_next;
    logic [1:0]    ch_reg, ch_next;
    logic [8:0]    x_reg, x_next;
    logic [2:0]    k_reg, k_next;
    logic          pass_reg, pass_next;
    logic signed [9:0] idx_n_reg, idx_n_next;
    logic signed [9:0] idx_p_reg, idx_p_next;
    logic [15:0]   addr_n_reg, addr_n_next;
    logic [15:0]   addr_p_reg, addr_p_next;
    logic [8:0]    sum_reg, sum_next;
    logic [23:0]   acc_reg, acc_next;

    // Derived configuration
    logic [7:0]  w_c;
    logic [7:0]  h_c;
    logic [2:0]  c_c;
    logic [9:0]  re_c;
    logic [3:0]  hk_c;
    logic [7:0]  er_c;
    logic [7:0]  rows_c;

    // Shared multiplier
    logic [9:0]  mul_a;
    logic [7:0]  mul_b;
    logic [17:0] prod;

    // Tap datapath
    logic [6:0]        base;
    logic [7:0]        fsize;
    logic [2:0]        off;
    logic [3:0]        off_w;
    logic signed [9:0] base_s;
    logic signed [9:0] off_s;
    logic signed [9:0] fsize_s;
    logic signed [9:0] fold_n;
    logic signed [9:0] fold_p;
    logic              fold_done;
    logic              is_center;
    logic [7:0]        weight;
    logic [9:0]        stride;
    logic [8:0]        offs;
    logic [15:0]       addr_calc;
    logic [23:0]       acc_rnd;
    logic [15:0]       lp_wrap;
    logic [16:0]       lp_inc;
    logic [16:0]       pos_inc;
    logic              accept;

    // Memory ports
    logic                frame_we;
    logic [FRAME_AW-1:0] frame_addr;
    logic [7:0]          frame_rdata;
    logic                row_we;
    logic [ROW_AW-1:0]   row_addr;
    logic [7:0]          row_rdata;
    logic [7:0]          mem_rdata;

    // Divider
    logic              div_start;
    logic [DIV_NW-1:0] div_dividend;
    logic [DIV_DW-1:0] div_divisor;
    logic [DIV_NW-1:0] div_quo;
    logic [DIV_DW-1:0] div_rem;
    logic              div_done;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    // Clamp dimensions and stripe
    always_comb
    begin
        if (image_width_reg == 8'd0) w_c = 8'd1;
        else if (image_width_reg > 8'(MAX_WIDTH)) w_c = 8'(MAX_WIDTH);
        else w_c = image_width_reg;
        if (image_height_reg == 8'd0) h_c = 8'd1;
        else if (image_height_reg > 8'(MAX_HEIGHT)) h_c = 8'(MAX_HEIGHT);
        else h_c = image_height_reg;
        if (channel_count_reg == 3'd0) c_c = 3'd1;
        else if (channel_count_reg > 3'(MAX_CHANNELS)) c_c = 3'(MAX_CHANNELS);
        else c_c = channel_count_reg;
        case (c_c)
            3'd2:    re_c = {1'b0, w_c, 1'b0};
            3'd3:    re_c = {2'b00, w_c} + {1'b0, w_c, 1'b0};
            3'd4:    re_c = {w_c, 2'b00};
            default: re_c = {2'b00, w_c};
        endcase
        hk_c   = (half_taps_reg > 4'(MAX_HALF_TAPS)) ? 4'(MAX_HALF_TAPS) : half_taps_reg;
        er_c   = (end_row_reg > h_c) ? h_c : end_row_reg;
        rows_c = er_c - {1'b0, first_row_reg};
    end

    // Tap operands
    always_comb
    begin
        base      = pass_reg ? px_reg : y_reg;
        fsize     = pass_reg ? w_c : h_c;
        off_w     = hk_c - 4'd1 - {1'b0, k_reg};
        off       = off_w[2:0];
        base_s    = signed'({3'b000, base});
        off_s     = signed'({7'b0000000, off});
        fsize_s   = signed'({2'b00, fsize});
        fold_n    = fold_step(idx_n_reg, fsize, border_mode_reg);
        fold_p    = fold_step(idx_p_reg, fsize, border_mode_reg);
        fold_done = (idx_n_reg >= 10'sd0) && (idx_n_reg < fsize_s)
                    && (idx_p_reg >= 10'sd0) && (idx_p_reg < fsize_s);
        is_center = ({1'b0, k_reg} == (hk_c - 4'd1));
        weight    = tap_weights_reg[{k_reg, 3'b000} +: 8];
        stride    = pass_reg ? {7'b0000000, c_c} : re_c;
        offs      = pass_reg ? {7'b0000000, ch_reg} : x_reg;
        addr_calc = prod[15:0] + {7'b0000000, offs};
        acc_rnd   = acc_reg + 24'd128;
        lp_wrap   = ({1'b0, lp_reg} >= ft_reg) ? 16'd0 : lp_reg;
        lp_inc    = {1'b0, lp_wrap} + 17'd1;
        pos_inc   = {1'b0, pos_reg} + 17'd1;
        mem_rdata = pass_reg ? row_rdata : frame_rdata;
    end

    // Select multiplier operands
    always_comb
    begin
        case (state_reg)
            S_L_PREP:
            begin
                mul_a = re_c;
                mul_b = h_c;
            end
            S_R_PREP:
            begin
                mul_a = re_c;
                mul_b = rows_c;
            end
            S_C_ADDR:
            begin
                mul_a = re_c;
                mul_b = {1'b0, y_reg};
            end
            S_T_ADDN:
            begin
                mul_a = stride;
                mul_b = {1'b0, idx_n_reg[6:0]};
            end
            S_T_ADDP:
            begin
                mul_a = stride;
                mul_b = {1'b0, idx_p_reg[6:0]};
            end
            S_T_MAC:
            begin
                mul_a = {1'b0, sum_reg};
                mul_b = weight;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {8'd0, mul_a} * {10'd0, mul_b};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd.func == FUNC_REQUEST) ? S_R_PREP : S_L_PREP;
                end
            end
            S_L_PREP:  state_next = S_L_WRITE;
            S_L_WRITE: state_next = S_IDLE;
            S_R_PREP:
            begin
                state_next = ({1'b0, first_row_reg} >= er_c) ? S_IDLE : S_R_WRAP;
            end
            S_R_WRAP:  state_next = S_D1_GO;
            S_D1_GO:   state_next = S_D1_WAIT;
            S_D1_WAIT: state_next = div_done ? S_D2_GO : S_D1_WAIT;
            S_D2_GO:   state_next = S_D2_WAIT;
            S_D2_WAIT:
            begin
                if (div_done)
                begin
                    state_next = (hk_c == 4'd0) ? S_C_ADDR : S_T_IDX;
                end
            end
            S_C_ADDR:  state_next = S_C_READ;
            S_C_READ:  state_next = S_FIN;
            S_T_IDX:   state_next = S_T_FOLD;
            S_T_FOLD:  state_next = fold_done ? S_T_ADDN : S_T_FOLD;
            S_T_ADDN:  state_next = S_T_ADDP;
            S_T_ADDP:  state_next = S_T_RDP;
            S_T_RDP:   state_next = S_T_SUM;
            S_T_SUM:   state_next = S_T_MAC;
            S_T_MAC:
            begin
                if (!is_center) state_next = S_T_IDX;
                else state_next = pass_reg ? S_FIN : S_V_WRITE;
            end
            S_V_WRITE: state_next = S_T_IDX;
            S_FIN:     state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        in_next      = in_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        lp_next      = lp_reg;
        pos_next     = pos_reg;
        ft_next      = ft_reg;
        total_next   = total_reg;
        y_next       = y_reg;
        col_next     = col_reg;
        px_next      = px_reg;
        ch_next      = ch_reg;
        x_next       = x_reg;
        k_next       = k_reg;
        pass_next    = pass_reg;
        idx_n_next   = idx_n_reg;
        idx_p_next   = idx_p_reg;
        addr_n_next  = addr_n_reg;
        addr_p_next  = addr_p_reg;
        sum_next     = sum_reg;
        acc_next     = acc_reg;
        frame_we     = 1'b0;
        frame_addr   = addr_n_reg;
        row_we       = 1'b0;
        row_addr     = addr_n_reg[ROW_AW-1:0];
        div_start    = 1'b0;
        div_dividend = pos_reg;
        div_divisor  = re_c;
        case (state_reg)
            S_IDLE:
            begin
                if (accept) in_next = cmd;
            end
            S_L_PREP:
            begin
                ft_next = prod[16:0];
            end
            S_L_WRITE:
            begin
                // Store the byte and advance the load position
                frame_we   = 1'b1;
                frame_addr = lp_wrap;
                lp_next    = (lp_inc >= ft_reg) ? 16'd0 : lp_inc[15:0];
            end
            S_R_PREP:
            begin
                total_next = prod[16:0];
            end
            S_R_WRAP:
            begin
                if ({1'b0, pos_reg} >= total_reg) pos_next = 16'd0;
            end
            S_D1_GO:
            begin
                div_start = 1'b1;
            end
            S_D1_WAIT:
            begin
                if (div_done)
                begin
                    y_next   = 7'({1'b0, first_row_reg} + {1'b0, div_quo[6:0]});
                    col_next = div_rem[8:0];
                end
            end
            S_D2_GO:
            begin
                div_start    = 1'b1;
                div_dividend = {7'd0, col_reg};
                div_divisor  = {7'd0, c_c};
            end
            S_D2_WAIT:
            begin
                if (div_done)
                begin
                    px_next   = div_quo[6:0];
                    ch_next   = div_rem[1:0];
                    k_next    = '0;
                    acc_next  = '0;
                    x_next    = '0;
                    // Refresh the row buffer at the start of a stripe row
                    pass_next = (col_reg != 9'd0);
                end
            end
            S_C_ADDR:
            begin
                addr_n_next = prod[15:0] + {7'd0, col_reg};
            end
            S_C_READ:
            begin
                frame_addr = addr_n_reg;
            end
            S_T_IDX:
            begin
                // Raw neighbor coordinates, folded back into range one step a cycle
                idx_n_next = base_s - off_s;
                idx_p_next = base_s + off_s;
            end
            S_T_FOLD:
            begin
                idx_n_next = fold_n;
                idx_p_next = fold_p;
            end
            S_T_ADDN:
            begin
                addr_n_next = addr_calc;
            end
            S_T_ADDP:
            begin
                addr_p_next = addr_calc;
                frame_addr  = addr_n_reg;
                row_addr    = addr_n_reg[ROW_AW-1:0];
            end
            S_T_RDP:
            begin
                frame_addr = addr_p_reg;
                row_addr   = addr_p_reg[ROW_AW-1:0];
                sum_next   = {1'b0, mem_rdata};
            end
            S_T_SUM:
            begin
                // Center tap counts once
                if (!is_center) sum_next = sum_reg + {1'b0, mem_rdata};
            end
            S_T_MAC:
            begin
                acc_next = acc_reg + {6'd0, prod};
                k_next   = k_reg + 3'd1;
            end
            S_V_WRITE:
            begin
                row_we   = 1'b1;
                row_addr = x_reg;
                k_next   = '0;
                acc_next = '0;
                if ({1'b0, x_reg} == re_c - 10'd1)
                begin
                    pass_next = 1'b1;
                end
                else
                begin
                    x_next = x_reg + 9'd1;
                end
            end
            S_FIN:
            begin
                // Emit one byte and advance the output position
                result_next.out_value  = (hk_c == 4'd0) ? frame_rdata : acc_rnd[15:8];
                result_next.last_value = (pos_inc >= total_reg);
                pos_next  = (pos_inc >= total_reg) ? 16'd0 : pos_inc[15:0];
                done_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            lp_reg            <= '0;
            pos_reg           <= '0;
            done_reg          <= 1'b0;
            image_width_reg   <= 8'd1;
            image_height_reg  <= 8'd1;
            channel_count_reg <= 3'd1;
            half_taps_reg     <= 4'd0;
            tap_weights_reg   <= '0;
            border_mode_reg   <= BORDER_REPLICATE;
            first_row_reg     <= 7'd0;
            end_row_reg       <= 8'd1;
        end
        else
        begin
            state_reg <= state_next;
            lp_reg    <= lp_next;
            pos_reg   <= pos_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[7:0];
                    REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[7:0];
                    REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[2:0];
                    REG_HALF_TAPS:     half_taps_reg     <= cfg_data[3:0];
                    REG_TAP_WEIGHTS:   tap_weights_reg   <= cfg_data;
                    REG_BORDER_MODE:   border_mode_reg   <= cfg_data[1:0];
                    REG_FIRST_ROW:     first_row_reg     <= cfg_data[6:0];
                    REG_END_ROW:       end_row_reg       <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_reg     <= in_next;
        result_reg <= result_next;
        ft_reg     <= ft_next;
        total_reg  <= total_next;
        y_reg      <= y_next;
        col_reg    <= col_next;
        px_reg     <= px_next;
        ch_reg     <= ch_next;
        x_reg      <= x_next;
        k_reg      <= k_next;
        pass_reg   <= pass_next;
        idx_n_reg  <= idx_n_next;
        idx_p_reg  <= idx_p_next;
        addr_n_reg <= addr_n_next;
        addr_p_reg <= addr_p_next;
        sum_reg    <= sum_next;
        acc_reg    <= acc_next;
    end

    sgb_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (frame_we),
        .addr  (frame_addr),
        .wdata (in_reg.pixel_value),
        .rdata (frame_rdata)
    );

    sgb_ram #(
        .WIDTH (8),
        .DEPTH (ROW_DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .addr  (row_addr),
        .wdata (acc_rnd[15:8]),
        .rdata (row_rdata)
    );

    sgb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

`ifndef SYNTHESIS
    a_done_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_FIN)) else $error("result without finish step");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result shown while busy");
    a_load_path: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.func == FUNC_LOAD)) |=> (state_reg == S_L_PREP))
        else $error("load transaction not started");
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_D1_WAIT || state_reg == S_D2_WAIT))
        else $error("divider finished outside a wait");
`endif

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
    import sgb_pkg::*;

    localparam int QUIET_LIMIT  = 100000;
    localparam int TARGET_ITEMS = 1500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    sgb_in_t     cmd = '0;
    logic        done;
    sgb_out_t    result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    separable_gaussian_blur_u8 u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's registers and storage
    logic [7:0]  width_reg  = 8'd1;
    logic [7:0]  height_reg = 8'd1;
    logic [2:0]  chan_reg   = 3'd1;
    logic [3:0]  taps_reg   = 4'd0;
    logic [63:0] weight_reg = '0;
    logic [1:0]  border_reg = BORDER_REPLICATE;
    logic [6:0]  first_reg  = '0;
    logic [7:0]  end_reg    = 8'd1;

    logic [7:0]  frame_mem [0:FRAME_DEPTH-1];
    logic [7:0]  row_mem [0:ROW_DEPTH-1];
    int unsigned load_pos = 0;
    int unsigned out_pos = 0;

    sgb_in_t  pending_cmds[$];
    sgb_out_t expected_pixels[$];
    int       fail_count = 0;
    int       item_count = 0;
    int       burst_left = 0;
    int       gap_left = 0;
    int       quiet_cycles = 0;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        return (v < 1) ? 1 : ((v > hi) ? hi : v);
    endfunction

    // Map a coordinate outside 0..size-1 back in, per border mode
    function automatic int border_coord(int idx, int size);
        int per;
        int p;
        if (idx >= 0 && idx < size) return idx;
        if (size <= 1) return 0;
        case (border_reg)
            BORDER_REFLECT:
            begin
                per = 2 * (size - 1);
                p = (idx < 0) ? -idx : idx;
                p = p % per;
                return (p < size) ? p : per - p;
            end
            BORDER_WRAP:
            begin
                p = idx % size;
                return (p < 0) ? p + size : p;
            end
            BORDER_REVERSE:
            begin
                per = 2 * size;
                p = (idx < 0) ? -(idx + 1) : idx;
                p = p % per;
                return (p < size) ? p : per - 1 - p;
            end
            default:
                return (idx < 0) ? 0 : size - 1;
        endcase
    endfunction

    function automatic int unsigned weight_of(int unsigned i);
        return int'((weight_reg >> (8 * (i & 7))) & 64'hFF);
    endfunction

    // Vertical pass of one row into the row buffer
    function automatic void blur_rows(int unsigned y, int unsigned re, int unsigned h,
                                      int unsigned hk);
        int unsigned acc;
        int unsigned yn;
        int unsigned yp;
        int off;
        for (int unsigned x = 0; x < re; x++)
        begin
            acc = frame_mem[y * re + x] * weight_of(hk - 1);
            for (int unsigned i = 0; i + 1 < hk; i++)
            begin
                off = hk - 1 - i;
                yn = border_coord(int'(y) - off, h);
                yp = border_coord(int'(y) + off, h);
                acc += (frame_mem[yn * re + x] + frame_mem[yp * re + x]) * weight_of(i);
            end
            row_mem[x] = 8'((acc + 128) >> 8);
        end
    endfunction

    // Advance the shadow state by one command and queue its output byte, if any
    function automatic void blur_command(sgb_in_t c);
        int unsigned w;
        int unsigned h;
        int unsigned ch;
        int unsigned re;
        int unsigned hk;
        int unsigned er;
        int unsigned total;
        int unsigned y;
        int unsigned col;
        int unsigned px;
        int unsigned chn;
        int unsigned acc;
        int unsigned xn;
        int unsigned xp;
        int off;
        sgb_out_t r;
        w  = clamp_dim(width_reg, MAX_WIDTH);
        h  = clamp_dim(height_reg, MAX_HEIGHT);
        ch = clamp_dim(chan_reg, MAX_CHANNELS);
        re = w * ch;
        hk = (taps_reg > 8) ? 8 : taps_reg;
        er = (end_reg > h) ? h : end_reg;
        if (c.func == FUNC_LOAD)
        begin
            if (load_pos >= re * h) load_pos = 0;
            frame_mem[load_pos] = c.pixel_value;
            load_pos++;
            if (load_pos >= re * h) load_pos = 0;
            return;
        end
        if (first_reg >= er) return;
        total = (er - first_reg) * re;
        if (out_pos >= total) out_pos = 0;
        y   = first_reg + out_pos / re;
        col = out_pos % re;
        if (hk == 0)
        begin
            r.out_value = frame_mem[y * re + col];
        end
        else
        begin
            if (col == 0) blur_rows(y, re, h, hk);
            px  = col / ch;
            chn = col % ch;
            acc = row_mem[col] * weight_of(hk - 1);
            for (int unsigned i = 0; i + 1 < hk; i++)
            begin
                off = hk - 1 - i;
                xn = border_coord(int'(px) - off, w);
                xp = border_coord(int'(px) + off, w);
                acc += (row_mem[xn * ch + chn] + row_mem[xp * ch + chn]) * weight_of(i);
            end
            r.out_value = 8'((acc + 128) >> 8);
        end
        out_pos++;
        r.last_value = (out_pos >= total);
        if (out_pos >= total) out_pos = 0;
        expected_pixels.push_back(r);
    endfunction

    // Clock and reset
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: feed queued commands in bursts separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy) blur_command(cmd);
            if (!start || !busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd   <= pending_cmds.pop_front();
                    start <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Track register writes in the shadow copy
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:   width_reg  = cfg_data[7:0];
                REG_IMAGE_HEIGHT:  height_reg = cfg_data[7:0];
                REG_CHANNEL_COUNT: chan_reg   = cfg_data[2:0];
                REG_HALF_TAPS:     taps_reg   = cfg_data[3:0];
                REG_TAP_WEIGHTS:   weight_reg = cfg_data;
                REG_BORDER_MODE:   border_reg = cfg_data[1:0];
                REG_FIRST_ROW:     first_reg  = cfg_data[6:0];
                REG_END_ROW:       end_reg    = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Monitor: compare each output byte with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("unexpected result transaction: out_value %0d", result.out_value);
                fail_count++;
            end
            else
            begin
                sgb_out_t e;
                e = expected_pixels.pop_front();
                if (result.out_value !== e.out_value)
                begin
                    $error("out_value: expected %0d, actual %0d", e.out_value, result.out_value);
                    fail_count++;
                end
                if (result.last_value !== e.last_value)
                begin
                    $error("last_value: expected %0d, actual %0d",
                           e.last_value, result.last_value);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transaction at all
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Hold until the block has drained everything
    task automatic wait_quiet();
        do @(posedge clk);
        while (pending_cmds.size() != 0 || start || busy || expected_pixels.size() != 0);
        repeat (50) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [63:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic push_cmd(logic f, logic [7:0] v);
        sgb_in_t c;
        c.func = f;
        c.pixel_value = v;
        pending_cmds.push_back(c);
    endtask

    // Configure, load the whole frame, then request whole stripes with loads mixed in
    task automatic run_phase(int w, int h, int ch, int taps, logic [63:0] wts, int mode,
                             int fr, int er, int stripes, int mix_pct);
        int unsigned re;
        int unsigned hh;
        int unsigned erc;
        int unsigned total;
        wait_quiet();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_CHANNEL_COUNT, ch);
        write_reg(REG_HALF_TAPS, taps);
        write_reg(REG_TAP_WEIGHTS, wts);
        write_reg(REG_BORDER_MODE, mode);
        write_reg(REG_FIRST_ROW, fr);
        write_reg(REG_END_ROW, er);
        cfg_valid <= 1'b0;
        re  = clamp_dim(w, MAX_WIDTH) * clamp_dim(ch, MAX_CHANNELS);
        hh  = clamp_dim(h, MAX_HEIGHT);
        erc = (er > hh) ? hh : er;
        for (int unsigned i = 0; i < re * hh; i++)
        begin
            push_cmd(FUNC_LOAD, $urandom_range(0, 255));
            item_count++;
        end
        if (fr >= erc)
        begin
            // empty stripe: requests give nothing
            repeat (stripes) push_cmd(FUNC_REQUEST, $urandom_range(0, 255));
            item_count += stripes;
            return;
        end
        total = (erc - fr) * re * stripes;
        for (int unsigned i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 99) < mix_pct)
            begin
                push_cmd(FUNC_LOAD, $urandom_range(0, 255));
                item_count++;
            end
            push_cmd(FUNC_REQUEST, $urandom_range(0, 255));
            item_count++;
        end
    endtask

    // Stimulus
    initial
    begin
        int w;
        int h;
        int fr;
        while (!rst_n) @(posedge clk);
        @(posedge clk);

        // Defaults from reset: plain copy of a single pixel
        push_cmd(FUNC_LOAD, 8'hFF);
        push_cmd(FUNC_REQUEST, 8'h00);
        push_cmd(FUNC_REQUEST, 8'hFF);
        item_count += 3;

        // Zero sizes clamp to one; oversized channel count clamps to four
        run_phase(0, 0, 0, 0, 64'h0, BORDER_REPLICATE, 0, 1, 1, 0);
        run_phase(2, 2, 7, 2, 64'hFFFF_FFFF_FFFF_FFFF, BORDER_REFLECT, 0, 255, 1, 0);
        // Single column and row under full taps in wrap and reverse modes
        run_phase(1, 1, 1, 15, 64'h0102_0408_1020_4080, BORDER_WRAP, 0, 1, 1, 0);
        run_phase(1, 1, 1, 8, 64'h8040_2010_0804_0201, BORDER_REVERSE, 0, 1, 1, 0);
        // Empty stripe
        run_phase(1, 3, 1, 1, 64'h55, BORDER_REPLICATE, 2, 1, 4, 0);
        // Widest row and tallest image, last row only
        run_phase(255, 1, 1, 8, 64'hFFFF_FFFF_FFFF_FFFF, BORDER_REVERSE, 0, 1, 1, 0);
        run_phase(1, 128, 1, 8, {$urandom, $urandom}, BORDER_REFLECT, 127, 128, 2, 0);

        // Random phases, mostly small frames
        while (item_count < TARGET_ITEMS)
        begin
            w = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
            h = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 5);
            fr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(0, (h > 1) ? h - 1 : 0);
            run_phase(w, h, $urandom_range(0, 7), $urandom_range(0, 15),
                      {$urandom, $urandom}, $urandom_range(0, 3), fr,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                  : fr + $urandom_range(1, 3),
                      $urandom_range(1, 2), $urandom_range(0, 30));
        end

        wait_quiet();
        repeat (100) @(posedge clk);
        if (fail_count == 0 && expected_pixels.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
